>>> rtl/core/jh2d_pkg.sv
// Shared types and constants of the two-dimensional joint histogram binner.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package jh2d_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_BINS      = 128;
    localparam int DEF_SLICES    = 4;
    localparam int DEF_SUM_WIDTH = 48;

    // Fixed field widths of the item and result formats.
    localparam int VAL_W     = 32;
    localparam int SLICE_FW  = 2;
    localparam int RD_BIN_W  = 7;
    localparam int OUT_SUM_W = 48;
    localparam int CFG_IDX_W = 3;

    // Depth of the command queue between the binning front and the update back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_A      = 3'd0,
        CFG_MIN_B      = 3'd1,
        CFG_SCALE_A    = 3'd2,
        CFG_SCALE_B    = 3'd3,
        CFG_BIN_WEIGHT = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } t_back_state;

    typedef struct packed {
        logic                       kind;
        logic [SLICE_FW-1:0]        slice;
        logic signed [VAL_W-1:0]    value_a;
        logic signed [VAL_W-1:0]    value_b;
        logic [RD_BIN_W-1:0]        read_bin_a;
        logic [RD_BIN_W-1:0]        read_bin_b;
    } t_item;

    typedef struct packed {
        logic                  in_range;
        logic [OUT_SUM_W-1:0]  bin_sum;
        logic                  saturated;
    } t_result;

    // Binning registers as seen by the front end.
    typedef struct packed {
        logic [VAL_W-1:0] min_a;
        logic [VAL_W-1:0] min_b;
        logic [VAL_W-1:0] scale_a;
        logic [VAL_W-1:0] scale_b;
    } t_bin_cfg;

    // Control part of one queued command; the bin address travels beside it.
    typedef struct packed {
        t_op  op;
        logic hit;
    } t_cmd_ctl;

endpackage

`default_nettype wire

>>> rtl/core/joint_histogram_2d_binner_unit.sv
// Top level of the per-slice two-dimensional joint histogram binner.
// Depends on jh2d_pkg, jh2d_front, jh2d_fifo, jh2d_back and jh2d_ram.
//
//   Channel   Direction  Handshake            Beat contents
//   -------   ---------  -------------------  ------------------------------------
//   item      in         i_push / o_full      t_item: kind, slice, values, read bins
//   result    out        o_empty / i_pop      t_result: in_range, bin_sum, saturated
//   config    in         i_cfg_valid/o_cfg_ready  register index and 32-bit data
//
// After reset the back end clears the bin store one entry per cycle, through all
// SLICES*BINS*BINS entries (65536 with the default sizes); o_full stays high meanwhile.
// An item is registered through the binning front, then waits in a four-entry queue.
// The back end takes a command only from BK_IDLE, reading its bin through the single
// port of the bin store, and in BK_EXEC writes the updated sum back for an in-range
// sample, so a new command is taken only once the last one has finished.
// A result that is not popped holds the back end; the queue then fills and o_full rises.
`default_nettype none

module joint_histogram_2d_binner_unit
    import jh2d_pkg::*;
#(
    parameter int BINS      = DEF_BINS,
    parameter int SLICES    = DEF_SLICES,
    parameter int SUM_WIDTH = DEF_SUM_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire t_item                 i_item,
    output logic                       o_full,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output t_result                    o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [VAL_W-1:0]      i_cfg_data
);

    localparam int DEPTH  = SLICES * BINS * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMD_W  = $bits(t_cmd_ctl) + ADDR_W;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers; the port is always ready.
    t_bin_cfg          r_cfg;
    logic [VAL_W-1:0]  r_weight;

    logic              accept;
    logic [1:0]        inflight;
    logic              cmd_push;
    t_cmd_ctl          cmd_ctl;
    logic [ADDR_W-1:0] cmd_addr;
    logic [CMD_W-1:0]  q_rdata;
    t_cmd_ctl          q_ctl;
    logic [ADDR_W-1:0] q_addr;
    logic              q_empty;
    logic              q_pop;
    logic [CNT_W-1:0]  q_count;
    logic              clearing;
    logic [CNT_W:0]    committed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_a   <= '0;
            r_cfg.min_b   <= '0;
            r_cfg.scale_a <= VAL_W'(65536);
            r_cfg.scale_b <= VAL_W'(65536);
            r_weight      <= VAL_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_A:      r_cfg.min_a   <= i_cfg_data;
                CFG_MIN_B:      r_cfg.min_b   <= i_cfg_data;
                CFG_SCALE_A:    r_cfg.scale_a <= i_cfg_data;
                CFG_SCALE_B:    r_cfg.scale_b <= i_cfg_data;
                CFG_BIN_WEIGHT: r_weight      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Every item in the front pipeline already owns a queue slot, so the front
    // never has to stall: input is refused once queue plus pipeline fill the queue.
    assign committed = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(inflight);
    assign o_full    = clearing || (committed >= (CNT_W + 1)'(QUEUE_DEPTH));
    assign accept    = i_push && !o_full;

    jh2d_front #(
        .BINS   (BINS),
        .SLICES (SLICES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_inflight (inflight),
        .o_push     (cmd_push),
        .o_ctl      (cmd_ctl),
        .o_addr     (cmd_addr)
    );

    jh2d_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata ({cmd_ctl, cmd_addr}),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign {q_ctl, q_addr} = q_rdata;

    jh2d_back #(
        .SUM_WIDTH (SUM_WIDTH),
        .DEPTH     (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (q_empty),
        .i_ctl        (q_ctl),
        .i_addr       (q_addr),
        .i_weight     (r_weight),
        .i_pop        (i_pop),
        .o_fifo_pop   (q_pop),
        .o_clearing   (clearing),
        .o_empty      (o_empty),
        .o_result     (o_result)
    );

    // The credit scheme must keep the queue from ever overflowing.
    a_queue_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> (q_count != CNT_W'(QUEUE_DEPTH)))
        else $error("command pushed into a full queue");

    // While the store is being cleared nothing may be queued or waiting.
    a_clear_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> (q_empty && o_empty && (inflight == 2'd0)))
        else $error("item activity during the clearing pass");

    // Each command taken by the back end is executed in the next cycle, and its
    // result is on the ports from the edge after that.
    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> ##1 !o_empty)
        else $error("no result after a command was taken");

    // The back end only takes a command when the result register is free or being popped.
    a_no_result_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && !o_empty) |-> i_pop)
        else $error("command taken while an unread result is held");

endmodule

`default_nettype wire

>>> rtl/core/jh2d_ram.sv
// Generic single-port RAM with a registered read port.
// Depends on jh2d_pkg for its default sizes only.
`default_nettype none

module jh2d_ram
    import jh2d_pkg::*;
#(
    parameter int WIDTH = DEF_SUM_WIDTH,
    parameter int DEPTH = DEF_SLICES * DEF_BINS * DEF_BINS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/jh2d_fifo.sv
// Small register-based queue carrying binned commands from front to back.
// Depends on jh2d_pkg for its default depth.
`default_nettype none

module jh2d_fifo
    import jh2d_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_pop,
    output logic [WIDTH-1:0]                o_rdata,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_slot[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> rtl/core/jh2d_front.sv
// Front end: takes items, bins both values through a two-stage multiply
// pipeline and emits one command per item. Depends on jh2d_pkg.
`default_nettype none

module jh2d_front
    import jh2d_pkg::*;
#(
    parameter int BINS   = DEF_BINS,
    parameter int SLICES = DEF_SLICES
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_accept,
    input  wire t_item                                   i_item,
    input  wire t_bin_cfg                                i_cfg,
    output logic [1:0]                                   o_inflight,
    output logic                                         o_push,
    output t_cmd_ctl                                     o_ctl,
    output logic [$clog2(SLICES * BINS * BINS)-1:0]      o_addr
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int ADDR_W = $clog2(SLICES * BINS * BINS);
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = DIFF_W + VAL_W;

    // Stage 1: signed differences taken apart into sign and magnitude.
    logic                 r_s1_valid, n_s1_valid;
    t_op                  r_s1_op, n_s1_op;
    logic [SLICE_FW-1:0]  r_s1_slice;
    logic [RD_BIN_W-1:0]  r_s1_ra, r_s1_rb;
    logic                 r_s1_neg_a, r_s1_neg_b;
    logic [DIFF_W-1:0]    r_s1_mag_a, r_s1_mag_b;

    // Stage 2: whole part of the scaled magnitudes.
    logic                 r_s2_valid, n_s2_valid;
    t_op                  r_s2_op;
    logic [SLICE_FW-1:0]  r_s2_slice;
    logic [RD_BIN_W-1:0]  r_s2_ra, r_s2_rb;
    logic                 r_s2_neg_a, r_s2_neg_b;
    logic [DIFF_W-1:0]    r_s2_whole_a, r_s2_whole_b;

    logic [DIFF_W-1:0]    n_diff_a, n_diff_b;
    logic [DIFF_W-1:0]    n_mag_a, n_mag_b;
    logic [PROD_W-1:0]    n_prod_a, n_prod_b;

    logic                 ok_a, ok_b, slice_ok, rd_ok, hit;
    logic [BIN_W-1:0]     idx_a, idx_b;
    logic [ADDR_W-1:0]    col, row;

    always_comb begin
        n_diff_a = {i_item.value_a[VAL_W-1], i_item.value_a}
                 - {i_cfg.min_a[VAL_W-1], i_cfg.min_a};
        n_diff_b = {i_item.value_b[VAL_W-1], i_item.value_b}
                 - {i_cfg.min_b[VAL_W-1], i_cfg.min_b};
        n_mag_a  = n_diff_a[DIFF_W-1] ? (~n_diff_a + 1'b1) : n_diff_a;
        n_mag_b  = n_diff_b[DIFF_W-1] ? (~n_diff_b + 1'b1) : n_diff_b;
        n_s1_op  = i_item.kind ? OP_READ : OP_SAMPLE;
        n_s1_valid = i_accept;
        n_s2_valid = r_s1_valid;
        n_prod_a = PROD_W'(r_s1_mag_a) * PROD_W'(i_cfg.scale_a);
        n_prod_b = PROD_W'(r_s1_mag_b) * PROD_W'(i_cfg.scale_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op      <= n_s1_op;
        r_s1_slice   <= i_item.slice;
        r_s1_ra      <= i_item.read_bin_a;
        r_s1_rb      <= i_item.read_bin_b;
        r_s1_neg_a   <= n_diff_a[DIFF_W-1];
        r_s1_neg_b   <= n_diff_b[DIFF_W-1];
        r_s1_mag_a   <= n_mag_a;
        r_s1_mag_b   <= n_mag_b;
        r_s2_op      <= r_s1_op;
        r_s2_slice   <= r_s1_slice;
        r_s2_ra      <= r_s1_ra;
        r_s2_rb      <= r_s1_rb;
        r_s2_neg_a   <= r_s1_neg_a;
        r_s2_neg_b   <= r_s1_neg_b;
        r_s2_whole_a <= n_prod_a[PROD_W-1:VAL_W];
        r_s2_whole_b <= n_prod_b[PROD_W-1:VAL_W];
    end

    // A negative difference lands in bin zero only when its product is above -1.
    always_comb begin
        ok_a  = r_s2_neg_a ? (r_s2_whole_a == '0) : (r_s2_whole_a < DIFF_W'(BINS));
        ok_b  = r_s2_neg_b ? (r_s2_whole_b == '0) : (r_s2_whole_b < DIFF_W'(BINS));
        idx_a = r_s2_neg_a ? '0 : r_s2_whole_a[BIN_W-1:0];
        idx_b = r_s2_neg_b ? '0 : r_s2_whole_b[BIN_W-1:0];
        slice_ok = (32'(r_s2_slice) < SLICES);
        rd_ok    = (32'(r_s2_ra) < BINS) && (32'(r_s2_rb) < BINS);
        if (r_s2_op == OP_READ) begin
            hit = slice_ok && rd_ok;
            col = ADDR_W'(r_s2_ra);
            row = ADDR_W'(r_s2_rb);
        end else begin
            hit = slice_ok && ok_a && ok_b;
            col = ADDR_W'(idx_a);
            row = ADDR_W'(idx_b);
        end
        o_ctl.op  = r_s2_op;
        o_ctl.hit = hit;
        o_addr    = hit ? (ADDR_W'(r_s2_slice) * ADDR_W'(BINS * BINS)
                          + row * ADDR_W'(BINS) + col) : '0;
    end

    assign o_push     = r_s2_valid;
    assign o_inflight = {1'b0, r_s1_valid} + {1'b0, r_s2_valid};

endmodule

`default_nettype wire

>>> rtl/core/jh2d_back.sv
// Back end: clears the bin store after reset, then reads one bin per command and
// updates hit samples' bins, holds results for the consumer. Depends on jh2d_pkg.
`default_nettype none

module jh2d_back
    import jh2d_pkg::*;
#(
    parameter int SUM_WIDTH = DEF_SUM_WIDTH,
    parameter int DEPTH     = DEF_SLICES * DEF_BINS * DEF_BINS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_fifo_empty,
    input  wire t_cmd_ctl                 i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [VAL_W-1:0]         i_weight,
    input  wire logic                     i_pop,
    output logic                          o_fifo_pop,
    output logic                          o_clearing,
    output logic                          o_empty,
    output t_result                       o_result
);

    localparam int ADDR_W = $clog2(DEPTH);

    t_back_state          r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    t_cmd_ctl             r_ctl, n_ctl;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 take;
    logic                 ram_en, ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [SUM_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [SUM_WIDTH:0]   sum_ext;
    logic [SUM_WIDTH-1:0] sum_new;

    jh2d_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign take = (r_state == BK_IDLE) && !i_fifo_empty && (!r_out_valid || i_pop);

    always_comb begin
        case (r_state)
            BK_CLEAR: n_state = (r_clr_addr == ADDR_W'(DEPTH - 1)) ? BK_IDLE : BK_CLEAR;
            BK_IDLE:  n_state = take ? BK_EXEC : BK_IDLE;
            BK_EXEC:  n_state = BK_IDLE;
            default:  n_state = BK_CLEAR;
        endcase
    end

    // Saturating add: the stored sum never exceeds the all-ones maximum.
    always_comb begin
        sum_ext = {1'b0, ram_rdata} + (SUM_WIDTH + 1)'(i_weight);
        sum_new = sum_ext[SUM_WIDTH] ? '1 : sum_ext[SUM_WIDTH-1:0];
    end

    always_comb begin
        o_fifo_pop  = 1'b0;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = r_addr;
        ram_wdata   = sum_new;
        n_clr_addr  = r_clr_addr;
        n_ctl       = r_ctl;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        case (r_state)
            BK_CLEAR: begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                ram_addr   = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            BK_IDLE: begin
                if (take) begin
                    o_fifo_pop = 1'b1;
                    ram_en     = 1'b1;
                    ram_addr   = i_addr;
                    n_ctl      = i_ctl;
                    n_addr     = i_addr;
                end
            end
            BK_EXEC: begin
                ram_en      = (r_ctl.op == OP_SAMPLE) && r_ctl.hit;
                ram_we      = ram_en;
                n_out_valid = 1'b1;
                if (r_ctl.op == OP_SAMPLE) begin
                    n_out.in_range  = r_ctl.hit;
                    n_out.bin_sum   = '0;
                    n_out.saturated = r_ctl.hit && (&sum_new);
                end else begin
                    n_out.in_range  = 1'b0;
                    n_out.bin_sum   = r_ctl.hit ? OUT_SUM_W'(ram_rdata) : '0;
                    n_out.saturated = r_ctl.hit && (&ram_rdata);
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctl  <= n_ctl;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    assign o_clearing = (r_state == BK_CLEAR);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

endmodule

`default_nettype wire

>>> dv/jh2d_hist_checker.sv
// Checker for the joint histogram binner: watches the item, result and register channels,
// keeps its own copy of the binning registers and of every bin sum, and checks each result.
// Depends on jh2d_pkg only.
module jh2d_hist_checker
    import jh2d_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_item                 i_item,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  t_result               i_result,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [VAL_W-1:0]      i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_binned,
    output int                    o_saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W    = DEF_SUM_WIDTH;
    localparam int BIN_N    = DEF_BINS;
    localparam int ADDR_W   = SLICE_FW + 2 * RD_BIN_W;
    localparam logic [SUM_W-1:0] SUM_CEIL = '1;

    logic [VAL_W-1:0] lo_a, lo_b, step_a, step_b, weight;
    logic [SUM_W-1:0] bin_sums [0:(1 << ADDR_W) - 1];
    t_result          expected_q[$];
    t_result          want;
    int               mismatch_count, result_count, binned_count, saturated_count;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want_val);
        mismatch_count++;
        $display("[%0t] result beat %0d: %s is 0x%0h, predicted 0x%0h",
                 $realtime, result_count, field, got, want_val);
    endtask

    // Offset from the lower edge times bins-per-unit, truncated toward zero.
    function automatic bit quantize(input logic [VAL_W-1:0] value,
                                    input logic [VAL_W-1:0] lower,
                                    input logic [VAL_W-1:0] per_unit,
                                    output logic [RD_BIN_W-1:0] idx);
        logic [VAL_W:0]   offset;
        logic [VAL_W:0]   mag;
        logic [2*VAL_W:0] prod;
        logic [VAL_W:0]   whole;
        offset = {value[VAL_W-1], value} - {lower[VAL_W-1], lower};
        mag    = offset[VAL_W] ? (~offset + 1'b1) : offset;
        prod   = mag * per_unit;
        whole  = prod[2*VAL_W:VAL_W];
        idx    = offset[VAL_W] ? '0 : whole[RD_BIN_W-1:0];
        if (offset[VAL_W])
            return whole == '0;
        return whole < BIN_N;
    endfunction

    function automatic t_result bin_and_accumulate(input t_item it);
        t_result             r;
        logic [RD_BIN_W-1:0] ia, ib;
        logic [ADDR_W-1:0]   addr;
        logic [SUM_W:0]      acc;
        r = '0;
        if (it.kind == OP_SAMPLE) begin
            if (quantize(it.value_a, lo_a, step_a, ia) &&
                quantize(it.value_b, lo_b, step_b, ib)) begin
                addr = {it.slice, ib, ia};
                acc  = bin_sums[addr] + weight;
                if (acc > SUM_CEIL)
                    acc = SUM_CEIL;
                bin_sums[addr] = acc[SUM_W-1:0];
                r.in_range     = 1'b1;
                r.saturated    = (acc[SUM_W-1:0] == SUM_CEIL);
            end
        end else begin
            addr        = {it.slice, it.read_bin_b, it.read_bin_a};
            r.bin_sum   = bin_sums[addr];
            r.saturated = (bin_sums[addr] == SUM_CEIL);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lo_a   = '0;
            lo_b   = '0;
            step_a = 32'h0001_0000;
            step_b = 32'h0001_0000;
            weight = 32'd1;
            foreach (bin_sums[k])
                bin_sums[k] = '0;
            expected_q.delete();
            mismatch_count  = 0;
            result_count    = 0;
            binned_count    = 0;
            saturated_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_A:      lo_a   = i_cfg_data;
                    CFG_MIN_B:      lo_b   = i_cfg_data;
                    CFG_SCALE_A:    step_a = i_cfg_data;
                    CFG_SCALE_B:    step_b = i_cfg_data;
                    CFG_BIN_WEIGHT: weight = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                expected_q.insert(expected_q.size(), bin_and_accumulate(i_item));
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_result), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.in_range !== want.in_range)
                        report_mismatch("in_range", 64'(i_result.in_range),
                                        64'(want.in_range));
                    if (i_result.bin_sum !== want.bin_sum)
                        report_mismatch("bin_sum", 64'(i_result.bin_sum), 64'(want.bin_sum));
                    if (i_result.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(i_result.saturated),
                                        64'(want.saturated));
                    if (want.in_range)
                        binned_count++;
                    if (want.saturated)
                        saturated_count++;
                end
                result_count++;
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_q.size();
        o_checked    <= result_count;
        o_binned     <= binned_count;
        o_saturated  <= saturated_count;
    end

endmodule

>>> dv/testbench.sv
// Top of the joint histogram binner testbench: clock, reset, stimulus and the final verdict.
// Depends on jh2d_pkg, joint_histogram_2d_binner_unit and jh2d_hist_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jh2d_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 9;
    // The block clears 65536 bins after reset, then handles one beat at a time; 5 ms
    // leaves a wide margin for the whole run.
    localparam int TIMEOUT_NS      = 5_000_000;
    localparam int TAIL_CYCLES     = 16;
    localparam int BIN_COUNT       = DEF_BINS;
    localparam int HOT_BINS        = 8;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 260;
    // A full-rate burst of the largest weight into one bin carries its sum far past
    // 32 bits.
    localparam int SAT_BEATS       = 64;
    localparam int SAT_BIN_A       = 5;
    localparam int SAT_BIN_B       = 9;
    localparam logic [VAL_W-1:0] ONE = 32'h0001_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    t_item                item = '0;
    logic                 full;
    logic                 empty;
    logic                 pop = 1'b0;
    t_result              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_data = '0;

    int mismatches, pending, checked, binned, saturated_seen;

    // Stimulus bookkeeping. The current register values shape the random samples so
    // that most of them land in bins rather than falling off the edges.
    logic [VAL_W-1:0] cur_min_a = '0, cur_min_b = '0;
    logic [VAL_W-1:0] cur_scale_a = ONE, cur_scale_b = ONE;
    int               hot_a[HOT_BINS], hot_b[HOT_BINS], hot_s[HOT_BINS];
    int               items_sent = 0, settings_loaded = 0, burst_left = 1;
    bit               tx_bursty = 1'b1;
    bit               rx_eager = 1'b0;
    int               rx_left = 0;
    bit               rx_stall = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    joint_histogram_2d_binner_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_item      (item),
        .o_full      (full),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    jh2d_hist_checker u_hist_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_binned     (binned),
        .o_saturated  (saturated_seen)
    );

    // The result side alternates between runs of pops and stalls of random length.
    // Now and then a long pop run gives a stretch with no back pressure at all. In
    // eager mode pop simply stays high so the single-bin burst runs at full rate.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop <= 1'b0;
            rx_left = 0;
        end else if (rx_eager) begin
            pop <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_stall = !rx_stall;
                if (rx_stall)
                    rx_left = $urandom_range(1, 9);
                else if ($urandom_range(0, 3) == 0)
                    rx_left = $urandom_range(40, 120);
                else
                    rx_left = $urandom_range(1, 24);
            end
            rx_left--;
            pop <= !rx_stall;
        end
    end

    // A sample beat carries random read bins, which the block must ignore.
    function automatic t_item sample_beat(input logic [SLICE_FW-1:0] sl,
                                          input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        t_item it;
        it.kind       = OP_SAMPLE;
        it.slice      = sl;
        it.value_a    = a;
        it.value_b    = b;
        it.read_bin_a = RD_BIN_W'($urandom());
        it.read_bin_b = RD_BIN_W'($urandom());
        return it;
    endfunction

    // A read beat carries random values, which the block must ignore.
    function automatic t_item read_beat(input logic [SLICE_FW-1:0] sl,
                                        input logic [RD_BIN_W-1:0] ra,
                                        input logic [RD_BIN_W-1:0] rb);
        t_item it;
        it.kind       = OP_READ;
        it.slice      = sl;
        it.value_a    = $urandom();
        it.value_b    = $urandom();
        it.read_bin_a = ra;
        it.read_bin_b = rb;
        return it;
    endfunction

    // Picks a value for one quantity. A targeted pick lands anywhere inside bin
    // 'target'; a wide pick spreads over the whole range plus a margin on both
    // sides, which brings in small negative offsets and values past the last bin.
    function automatic logic [VAL_W-1:0] pick_value(input logic [VAL_W-1:0] lower,
                                                    input logic [VAL_W-1:0] per_unit,
                                                    input int target, input bit wide);
        longint span, first, last, offset, v;
        if (per_unit == '0)
            return $urandom();
        if (wide) begin
            span = (longint'(BIN_COUNT) <<< 32) / longint'(per_unit);
            if (span > 64'sh7FFF_FFFF)
                span = 64'sh7FFF_FFFF;
            offset = longint'($urandom_range(0, 32'(span + span / 4))) - span / 8;
        end else begin
            first = ((longint'(target) <<< 32) + longint'(per_unit) - 1) / longint'(per_unit);
            last  = ((longint'(target + 1) <<< 32) + longint'(per_unit) - 1)
                    / longint'(per_unit) - 1;
            if (last - first > 64'sh7FFF_FFFF)
                last = first + 64'sh7FFF_FFFF;
            offset = first + longint'($urandom_range(0, 32'(last - first)));
        end
        // The value field is only 32 bits, so far targets get clipped at the ends.
        v = longint'($signed(lower)) + offset;
        if (v > 64'sh7FFF_FFFF)
            v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            v = -64'sh8000_0000;
        return v[VAL_W-1:0];
    endfunction

    // Most of the traffic hammers a few hot bins so that sums build up and reads
    // return something; the rest is spread samples, pure noise and random reads.
    function automatic t_item random_beat();
        int pick, k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, HOT_BINS - 1);
        if (pick < 55)
            return sample_beat(SLICE_FW'(hot_s[k]),
                               pick_value(cur_min_a, cur_scale_a, hot_a[k], 1'b0),
                               pick_value(cur_min_b, cur_scale_b, hot_b[k], 1'b0));
        if (pick < 70)
            return sample_beat(SLICE_FW'($urandom()),
                               pick_value(cur_min_a, cur_scale_a, 0, 1'b1),
                               pick_value(cur_min_b, cur_scale_b, 0, 1'b1));
        if (pick < 75)
            return sample_beat(SLICE_FW'($urandom()), $urandom(), $urandom());
        if (pick < 90)
            return read_beat(SLICE_FW'(hot_s[k]), RD_BIN_W'(hot_a[k]), RD_BIN_W'(hot_b[k]));
        return read_beat(SLICE_FW'($urandom()), RD_BIN_W'($urandom()), RD_BIN_W'($urandom()));
    endfunction

    // Lower edges sit near zero most of the time, and anywhere now and then.
    function automatic logic [VAL_W-1:0] pick_lower();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    // Scales between an eighth of a bin and eight bins per unit, or anything at all.
    function automatic logic [VAL_W-1:0] pick_scale();
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return $urandom_range(32'h0000_2000, 32'h0008_0000);
    endfunction

    // Presents one item beat and returns at the edge that accepts it. push is only
    // lowered when a gap follows, so back-to-back beats keep it high throughout.
    task automatic send_beat(input t_item beat);
        int gap;
        item <= beat;
        push <= 1'b1;
        do @(posedge clk); while (full);
        items_sent++;
        if (tx_bursty) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 20);
                gap        = $urandom_range(0, 12);
                if (gap != 0) begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Stops pushing and waits until the checker holds no more expectations. The
    // first edge lets the checker's count take in a beat accepted just now.
    task automatic wait_results_drained();
        if (push)
            push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // cfg_valid stays high across consecutive register writes; the caller drops it.
    task automatic write_register(input t_cfg_idx idx, input logic [VAL_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic load_binning(input logic [VAL_W-1:0] min_a, input logic [VAL_W-1:0] min_b,
                                input logic [VAL_W-1:0] scale_a,
                                input logic [VAL_W-1:0] scale_b,
                                input logic [VAL_W-1:0] weight);
        wait_results_drained();
        write_register(CFG_MIN_A, min_a);
        write_register(CFG_MIN_B, min_b);
        write_register(CFG_SCALE_A, scale_a);
        write_register(CFG_SCALE_B, scale_b);
        write_register(CFG_BIN_WEIGHT, weight);
        cfg_valid <= 1'b0;
        cur_min_a   = min_a;
        cur_min_b   = min_b;
        cur_scale_a = scale_a;
        cur_scale_b = scale_b;
        settings_loaded++;
    endtask

    task automatic random_setting();
        logic [VAL_W-1:0] weight;
        weight = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64) : $urandom();
        load_binning(pick_lower(), pick_lower(), pick_scale(), pick_scale(), weight);
        for (int k = 0; k < HOT_BINS; k++) begin
            hot_a[k] = $urandom_range(0, BIN_COUNT - 1);
            hot_b[k] = $urandom_range(0, BIN_COUNT - 1);
            hot_s[k] = $urandom_range(0, 3);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: lower edges at zero and one bin per unit, so the bin index
        // is the integer part of the value. The first beat waits out the clearing pass.
        send_beat(sample_beat(2'd0, 32'h0000_0000, 32'h0000_0000));
        send_beat(sample_beat(2'd1, 32'h007F_FFFF, 32'h007F_FFFF));   // last bin on both axes
        send_beat(sample_beat(2'd2, 32'h0080_0000, 5 * ONE));         // A one past the last bin
        send_beat(sample_beat(2'd2, 5 * ONE, 32'h0080_0000));         // B one past the last bin
        // Slightly below the lower edge truncates toward zero and is counted in bin 0.
        send_beat(sample_beat(2'd3, 32'hFFFF_8000, 32'hFFFF_FFFF));
        send_beat(sample_beat(2'd3, 32'hFFFF_0000, 32'h0000_0000));   // a whole unit below
        send_beat(sample_beat(2'd0, 32'h7FFF_FFFF, 32'h8000_0000));
        send_beat(sample_beat(2'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_beat(sample_beat(2'd1, 64 * ONE, 32'h0020_8000));
        send_beat(sample_beat(2'd1, 64 * ONE + 32'h0000_FFFF, 32'h0020_0001));
        send_beat(read_beat(2'd0, 7'd0, 7'd0));
        send_beat(read_beat(2'd1, 7'd127, 7'd127));
        send_beat(read_beat(2'd3, 7'd0, 7'd0));
        send_beat(read_beat(2'd1, 7'd64, 7'd32));
        send_beat(read_beat(2'd2, 7'd127, 7'd0));
        send_beat(read_beat(2'd0, 7'd0, 7'd127));
        send_beat(read_beat(2'd2, 7'd5, 7'd0));

        // Extremes: a zero scale puts everything in bin 0, and a full scale makes
        // only offsets from one LSB below the edge to 128 LSBs above it land inside.
        load_binning(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(sample_beat(2'd0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_beat(sample_beat(2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFE));
        send_beat(sample_beat(2'd1, $urandom(), 32'h7FFF_FFFD));
        send_beat(read_beat(2'd0, 7'd0, 7'd0));

        // The same extremes with the two axes swapped.
        load_binning(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'd2);
        send_beat(sample_beat(2'd2, 32'h7FFF_FFFF, $urandom()));
        send_beat(sample_beat(2'd2, 32'h7FFF_FFFE, $urandom()));
        send_beat(sample_beat(2'd2, 32'h8000_0000, $urandom()));
        send_beat(read_beat(2'd2, 7'd0, 7'd0));

        // Random phases, each under a fresh register setting and hot-bin set.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setting();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_beat(random_beat());
        end

        // Pile the largest weight into one bin of the last slice at full rate, then
        // read it back, add once more and read again, with wide sums on the result.
        load_binning(32'h0000_0000, 32'h0000_0000, ONE, ONE, 32'hFFFF_FFFF);
        tx_bursty = 1'b0;
        rx_eager <= 1'b1;
        for (int n = 0; n < SAT_BEATS; n++)
            send_beat(sample_beat(2'd3, {16'(SAT_BIN_A), 16'($urandom())},
                                  {16'(SAT_BIN_B), 16'($urandom())}));
        tx_bursty = 1'b1;
        rx_eager <= 1'b0;
        send_beat(read_beat(2'd3, 7'(SAT_BIN_A), 7'(SAT_BIN_B)));
        send_beat(read_beat(2'd3, 7'(SAT_BIN_B), 7'(SAT_BIN_A)));
        send_beat(sample_beat(2'd3, SAT_BIN_A * ONE, SAT_BIN_B * ONE));
        send_beat(read_beat(2'd3, 7'(SAT_BIN_A), 7'(SAT_BIN_B)));

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d item beats under %0d register settings, %0d of them into one bin.",
                 items_sent, settings_loaded, SAT_BEATS);
        $display("Checked %0d result beats: %0d binned, %0d saturated, %0d mismatches.",
                 checked, binned, saturated_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #TIMEOUT_NS;
        $display("Timed out with %0d results outstanding.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
